### src/rotation_vector_to_quaternion_core_defines.svh
// assertion macros for the rotation vector to quaternion core
`ifndef ROTATION_VECTOR_TO_QUATERNION_CORE_DEFINES_SVH
`define ROTATION_VECTOR_TO_QUATERNION_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RVQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RVQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rvq_pkg.sv
// shared types, constants and elaboration-time functions of the quaternion core
`timescale 1ns / 1ps

package rvq_pkg;

  localparam int CORDIC_STAGES = 30;

  localparam int IN_W     = 32;
  localparam int SUM_W    = 64;
  localparam int T_W      = 32;
  localparam int SQRT_LAT = T_W;
  localparam int REM_W    = T_W + 2;
  localparam int XY_W     = 44;
  localparam int Z_W      = 60;
  localparam int H_SHIFT  = 27;
  localparam int DIV_BITS = 31;
  localparam int PROD_W   = T_W + DIV_BITS;

  localparam int CORDIC_LAT = CORDIC_STAGES + 3;
  localparam int LANE_LAT   = DIV_BITS + 3;
  localparam int ST_SUM     = 2;
  localparam int ST_T       = ST_SUM + SQRT_LAT;
  localparam int ST_CS      = ST_T + CORDIC_LAT;
  localparam int ST_Q       = ST_CS + LANE_LAT;

  typedef logic signed [IN_W-1:0] comp_t;
  typedef logic [2:0][IN_W-1:0] vec3_t;

  typedef struct packed {
    logic  small_ang;
    comp_t z;
    comp_t y;
    comp_t x;
    comp_t w;
  } quat_t;

  localparam comp_t ONE_Q30 = 32'sh4000_0000;
  localparam logic [SUM_W-1:0] SMALL_SUM_MAX = 64'd72057;

  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] PI4_Q56 = (PI_Q60 + 64'd32) >> 6;
  localparam logic [63:0] PI2_Q56 = (PI_Q60 + 64'd16) >> 5;

  // multiples of pi/2 removed per quadrant count
  localparam logic [63:0] KP2 [8] = '{
    64'd0, PI2_Q56, 64'd2 * PI2_Q56, 64'd3 * PI2_Q56,
    64'd4 * PI2_Q56, 64'd5 * PI2_Q56, 64'd6 * PI2_Q56, 64'd7 * PI2_Q56
  };

  // restoring long division, constants only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] num;
    logic [63:0] res;
    logic [63:0] bv;
    num = n;
    res = '0;
    for (int j = 0; j < 32; j++) begin
      bv = 64'd1 << (62 - 2 * j);
      if (num >= res + bv) begin
        num = num - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // start value of x: inverse cordic gain, q40
  function automatic logic signed [XY_W-1:0] cordic_x0();
    logic [63:0] p;
    logic [63:0] a;
    logic [63:0] kq;
    p = 64'd1 << 60;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (2 * i < 64) begin
        p = p + (p >> (2 * i));
      end
    end
    a  = isqrt64(p);
    kq = udiv64((64'd1 << 62) + (a >> 1), a);
    return XY_W'(kq << 8);
  endfunction

  // atan(2^-i) in q56 from a truncated series; for i = 0, pi/4 from the pi constant
  function automatic logic signed [Z_W-1:0] atan_q56(input int i);
    logic signed [63:0] s;
    logic [63:0] acc;
    logic [63:0] term;
    s = '0;
    if (i == 0) begin
      acc = PI_Q60;
    end else begin
      for (int n = 0; i * (2 * n + 1) <= 62; n++) begin
        term = udiv64(64'd1 << (62 - i * (2 * n + 1)), 64'(2 * n + 1));
        if (n % 2 == 1) s = s - $signed(term);
        else            s = s + $signed(term);
      end
      acc = s;
    end
    return Z_W'((acc + 64'd32) >> 6);
  endfunction

  // q40 to q30 with round half up and clamp to +-1
  function automatic comp_t to_q30(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] sh;
    sh = (v + XY_W'(512)) >>> 10;
    if (sh > XY_W'(ONE_Q30))       return ONE_Q30;
    else if (sh < -XY_W'(ONE_Q30)) return -ONE_Q30;
    else                           return IN_W'(sh);
  endfunction

endpackage

### src/rvq_isqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module rvq_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rvq_pkg::SUM_W-1:0]   sum,
  output logic [rvq_pkg::T_W-1:0]     root
);

  logic [rvq_pkg::SUM_W-1:0] rad_r  [rvq_pkg::SQRT_LAT];
  logic [rvq_pkg::REM_W-1:0] rem_r  [rvq_pkg::SQRT_LAT];
  logic [rvq_pkg::T_W-1:0]   root_r [rvq_pkg::SQRT_LAT];

  for (genvar j = 0; j < rvq_pkg::SQRT_LAT; j++) begin : g_st
    logic [rvq_pkg::SUM_W-1:0] rad_in;
    logic [rvq_pkg::REM_W-1:0] rem_in;
    logic [rvq_pkg::T_W-1:0]   root_in;
    logic [rvq_pkg::REM_W+1:0] acc;
    logic [rvq_pkg::REM_W+1:0] trial;

    if (j == 0) begin : g_first
      assign rad_in  = sum;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end

    assign acc   = {rem_in, rad_in[rvq_pkg::SUM_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j] <= {rad_in[rvq_pkg::SUM_W-3:0], 2'b00};
        if (acc >= trial) begin
          rem_r[j]  <= rvq_pkg::REM_W'(acc - trial);
          root_r[j] <= {root_in[rvq_pkg::T_W-2:0], 1'b1};
        end else begin
          rem_r[j]  <= rvq_pkg::REM_W'(acc);
          root_r[j] <= {root_in[rvq_pkg::T_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[rvq_pkg::SQRT_LAT-1];

endmodule

### src/rvq_cordic.sv
// half-angle quadrant reduction and pipelined rotation-mode cordic for cos and sin
`timescale 1ns / 1ps

module rvq_cordic (
  input  logic                    clk,
  input  logic                    en,
  input  logic [rvq_pkg::T_W-1:0] t,
  output rvq_pkg::comp_t          cos_q,
  output rvq_pkg::comp_t          sin_q
);

  localparam int N = rvq_pkg::CORDIC_STAGES;
  localparam int HW = rvq_pkg::T_W + rvq_pkg::H_SHIFT;
  localparam logic signed [rvq_pkg::XY_W-1:0] X0 = rvq_pkg::cordic_x0();

  logic [HW-1:0] h;
  logic [2:0]    kc;
  logic [HW-1:0] h_r;
  logic [2:0]    k1_r;
  logic signed [rvq_pkg::Z_W-1:0] z0_r;
  logic [1:0]    k2_r;

  logic signed [rvq_pkg::XY_W-1:0] x_r [N];
  logic signed [rvq_pkg::XY_W-1:0] y_r [N];
  logic signed [rvq_pkg::Z_W-1:0]  z_r [N];
  logic [1:0]                      kq_r [N];

  logic signed [rvq_pkg::XY_W-1:0] c_c;
  logic signed [rvq_pkg::XY_W-1:0] s_c;
  rvq_pkg::comp_t cos_r;
  rvq_pkg::comp_t sin_r;

  assign h = {t, {rvq_pkg::H_SHIFT{1'b0}}};

  // quadrant count: h is non-negative, thresholds are increasing
  always_comb begin
    kc = 3'd0;
    for (int m = 0; m < 7; m++) begin
      if (64'(h) > rvq_pkg::PI4_Q56 + 64'(m) * rvq_pkg::PI2_Q56) kc = 3'(m + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r  <= h;
      k1_r <= kc;
      z0_r <= rvq_pkg::Z_W'({1'b0, h_r}) - rvq_pkg::Z_W'(rvq_pkg::KP2[k1_r]);
      k2_r <= k1_r[1:0];
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_st
    localparam logic signed [rvq_pkg::Z_W-1:0] ANG = rvq_pkg::atan_q56(j);
    logic signed [rvq_pkg::XY_W-1:0] x_in;
    logic signed [rvq_pkg::XY_W-1:0] y_in;
    logic signed [rvq_pkg::Z_W-1:0]  z_in;
    logic [1:0]                      k_in;

    if (j == 0) begin : g_first
      assign x_in = X0;
      assign y_in = '0;
      assign z_in = z0_r;
      assign k_in = k2_r;
    end else begin : g_next
      assign x_in = x_r[j-1];
      assign y_in = y_r[j-1];
      assign z_in = z_r[j-1];
      assign k_in = kq_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        kq_r[j] <= k_in;
        if (!z_in[rvq_pkg::Z_W-1]) begin
          x_r[j] <= x_in - (y_in >>> j);
          y_r[j] <= y_in + (x_in >>> j);
          z_r[j] <= z_in - ANG;
        end else begin
          x_r[j] <= x_in + (y_in >>> j);
          y_r[j] <= y_in - (x_in >>> j);
          z_r[j] <= z_in + ANG;
        end
      end
    end
  end

  // put back the removed quarter turns
  always_comb begin
    case (kq_r[N-1])
      2'd1: begin
        c_c = -y_r[N-1];
        s_c = x_r[N-1];
      end
      2'd2: begin
        c_c = -x_r[N-1];
        s_c = -y_r[N-1];
      end
      2'd3: begin
        c_c = y_r[N-1];
        s_c = -x_r[N-1];
      end
      default: begin
        c_c = x_r[N-1];
        s_c = y_r[N-1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= rvq_pkg::to_q30(c_c);
      sin_r <= rvq_pkg::to_q30(s_c);
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

### src/rvq_lane.sv
// one component lane: |s|*|r| rounded and divided by the angle, pipelined divider
`timescale 1ns / 1ps

module rvq_lane (
  input  logic                    clk,
  input  logic                    en,
  input  rvq_pkg::comp_t          s,
  input  rvq_pkg::comp_t          r,
  input  logic [rvq_pkg::T_W-1:0] t,
  output rvq_pkg::comp_t          q
);

  localparam int NB = rvq_pkg::DIV_BITS;
  localparam int PW = rvq_pkg::PROD_W;
  localparam int TW = rvq_pkg::T_W;

  logic [TW-1:0] s_abs;
  logic [TW-1:0] r_abs;
  logic [PW-1:0] prod_c;

  logic [PW-1:0] prod_r;
  logic [TW-1:0] t1_r;
  logic          neg1_r;
  logic [PW-1:0] num_r;
  logic [TW-1:0] t2_r;
  logic          neg2_r;

  logic [TW-1:0] rem_r [NB];
  logic [NB-1:0] lo_r  [NB];
  logic [NB-1:0] quo_r [NB];
  logic [TW-1:0] td_r  [NB];
  logic          ng_r  [NB];

  logic [NB-1:0] mag;
  rvq_pkg::comp_t q_r;

  assign s_abs  = s[TW-1] ? TW'(-s) : TW'(s);
  assign r_abs  = r[TW-1] ? TW'(-r) : TW'(r);
  assign prod_c = PW'(s_abs[NB-1:0]) * PW'(r_abs);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_c;
      t1_r   <= t;
      neg1_r <= s[TW-1] ^ r[TW-1];
      num_r  <= prod_r + PW'(t1_r >> 1);
      t2_r   <= t1_r;
      neg2_r <= neg1_r;
    end
  end

  // quotient fits in NB bits: the numerator stays below t * 2^NB
  for (genvar j = 0; j < NB; j++) begin : g_st
    logic [TW-1:0] rem_in;
    logic [NB-1:0] lo_in;
    logic [NB-1:0] quo_in;
    logic [TW-1:0] t_in;
    logic          ng_in;
    logic [TW:0]   acc;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = num_r[PW-1:NB];
      assign lo_in  = num_r[NB-1:0];
      assign quo_in = '0;
      assign t_in   = t2_r;
      assign ng_in  = neg2_r;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign lo_in  = lo_r[j-1];
      assign quo_in = quo_r[j-1];
      assign t_in   = td_r[j-1];
      assign ng_in  = ng_r[j-1];
    end

    assign acc = {rem_in, lo_in[NB-1]};
    assign ge  = acc >= {1'b0, t_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? TW'(acc - {1'b0, t_in}) : TW'(acc);
        lo_r[j]  <= {lo_in[NB-2:0], 1'b0};
        quo_r[j] <= {quo_in[NB-2:0], ge};
        td_r[j]  <= t_in;
        ng_r[j]  <= ng_in;
      end
    end
  end

  assign mag = (quo_r[NB-1] > NB'(rvq_pkg::ONE_Q30)) ? NB'(rvq_pkg::ONE_Q30) : quo_r[NB-1];

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= ng_r[NB-1] ? -TW'(mag) : TW'(mag);
    end
  end

  assign q = q_r;

endmodule

### src/rotation_vector_to_quaternion_core.sv
// top level: rotation vector to unit quaternion, fully pipelined
//
//  channel  | dir | tdata (low bit up)                 | tuser
//  in_*     | in  | rot_x, rot_y, rot_z (3 x 32)       | -
//  out_*    | out | quat_w, quat_x, quat_y, quat_z     | small_angle
//
// one word per cycle sustained while the skid word is empty; the pipeline runs through
// the 32-stage square root, the cordic chain and the 31-stage lane dividers
// the whole pipeline moves on one enable; it holds only when the skid word is full
// a two-word output stage (output register plus skid) keeps in_tready registered
// reset clears valid bits only; payload registers carry no reset
`timescale 1ns / 1ps
`include "rotation_vector_to_quaternion_core_defines.svh"

module rotation_vector_to_quaternion_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // rot_x, rot_y, rot_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic         out_tuser   // small_angle
);

  localparam int STQ = rvq_pkg::ST_Q;
  localparam int STC = rvq_pkg::ST_CS;

  logic en;

  // valid per stage: vld_r[i] belongs to stage i+1
  logic vld_r [STQ];

  // lane front end: abs and square of each component
  rvq_pkg::vec3_t r1_r;
  logic [rvq_pkg::SUM_W-1:0] sq_r [3];
  logic [rvq_pkg::SUM_W-1:0] sum_r;
  logic small_c;

  logic [rvq_pkg::T_W-1:0] t_root;
  rvq_pkg::comp_t cos_q;
  rvq_pkg::comp_t sin_q;
  rvq_pkg::comp_t lane_q [3];

  // delay lines, d[i] is one stage later than its source plus i
  rvq_pkg::vec3_t          r_d  [STQ-1];
  logic [rvq_pkg::T_W-1:0] t_d  [rvq_pkg::CORDIC_LAT];
  rvq_pkg::comp_t          w_d  [rvq_pkg::LANE_LAT];
  logic                    sm_d [STQ-2];

  rvq_pkg::quat_t tail_c;
  logic out_valid_r;
  logic skid_valid_r;
  rvq_pkg::quat_t out_data_r;
  rvq_pkg::quat_t skid_data_r;
  logic take;
  logic incoming;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STQ; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < STQ; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // squares per lane, then merge into the exact sum
  for (genvar j = 0; j < 3; j++) begin : g_sq
    rvq_pkg::comp_t comp;
    logic [rvq_pkg::IN_W-1:0] mag;
    assign comp = in_tdata[j*rvq_pkg::IN_W +: rvq_pkg::IN_W];
    assign mag  = comp[rvq_pkg::IN_W-1] ? rvq_pkg::IN_W'(-comp) : rvq_pkg::IN_W'(comp);
    always_ff @(posedge clk) begin
      if (en) begin
        r1_r[j] <= comp;
        sq_r[j] <= rvq_pkg::SUM_W'(mag) * rvq_pkg::SUM_W'(mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  // below 1e-6 rad the series values are used
  assign small_c = sum_r <= rvq_pkg::SMALL_SUM_MAX;

  rvq_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .sum  (sum_r),
    .root (t_root)
  );

  rvq_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .t     (t_root),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      r_d[0]  <= r1_r;
      t_d[0]  <= t_root;
      w_d[0]  <= cos_q;
      sm_d[0] <= small_c;
      for (int i = 1; i < STQ - 1; i++) r_d[i] <= r_d[i-1];
      for (int i = 1; i < rvq_pkg::CORDIC_LAT; i++) t_d[i] <= t_d[i-1];
      for (int i = 1; i < rvq_pkg::LANE_LAT; i++) w_d[i] <= w_d[i-1];
      for (int i = 1; i < STQ - 2; i++) sm_d[i] <= sm_d[i-1];
    end
  end

  // three component lanes share sin and the angle
  for (genvar j = 0; j < 3; j++) begin : g_lane
    rvq_lane u_lane (
      .clk (clk),
      .en  (en),
      .s   (sin_q),
      .r   ($signed(r_d[STC-2][j])),
      .t   (t_d[rvq_pkg::CORDIC_LAT-1]),
      .q   (lane_q[j])
    );
  end

  // merge: pick the small-angle values or the lane results
  always_comb begin
    tail_c.small_ang = sm_d[STQ-3];
    if (sm_d[STQ-3]) begin
      tail_c.w = rvq_pkg::ONE_Q30;
      tail_c.x = {r_d[STQ-2][0][rvq_pkg::IN_W-2:0], 1'b0};
      tail_c.y = {r_d[STQ-2][1][rvq_pkg::IN_W-2:0], 1'b0};
      tail_c.z = {r_d[STQ-2][2][rvq_pkg::IN_W-2:0], 1'b0};
    end else begin
      tail_c.w = w_d[rvq_pkg::LANE_LAT-1];
      tail_c.x = lane_q[0];
      tail_c.y = lane_q[1];
      tail_c.z = lane_q[2];
    end
  end

  // output register plus skid word
  assign take     = out_valid_r && out_tready;
  assign incoming = en && vld_r[STQ-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (incoming) begin
      if (out_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) out_data_r <= skid_data_r;
    end else if (incoming) begin
      if (out_valid_r && !take) skid_data_r <= tail_c;
      else                      out_data_r  <= tail_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.z, out_data_r.y, out_data_r.x, out_data_r.w};
  assign out_tuser  = out_data_r.small_ang;

  `RVQ_ASSERT_NOW(a_skid_needs_out, skid_valid_r, out_valid_r, "skid word held with empty output")
  `RVQ_ASSERT_NOW(a_small_w_one, out_tvalid && out_tuser, $signed(out_tdata[31:0]) == rvq_pkg::ONE_Q30, "small angle word without unit w")
  `RVQ_ASSERT_NOW(a_w_range, out_tvalid, ($signed(out_tdata[31:0]) <= rvq_pkg::ONE_Q30) && ($signed(out_tdata[31:0]) >= -rvq_pkg::ONE_Q30), "w outside unit range")
  `RVQ_ASSERT_NEXT(a_stall_blocks_input, skid_valid_r && !out_tready, !in_tready, "input taken while both output words held")

endmodule
